### design/acsp_pkg.sv
package acsp_pkg;

  // Default width of the commanded value (the accumulator saturates at 2^n-1).
  localparam int VALUE_BITS_DEF = 12;

  // Register widths.
  localparam int OFFSET_W = 8;
  localparam int FT_W     = 12;
  localparam int FCOUNT_W = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [OFFSET_W-1:0] PULSE_OFFSET_RST = 8'd60;
  localparam logic [FT_W-1:0]     FRAME_TICKS_RST  = 12'd2000;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST  = 8'd50;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_OFFSET = 2'd0,
    REG_FRAME_TICKS  = 2'd1,
    REG_FRAME_COUNT  = 2'd2
  } reg_idx_t;

  // Characters.
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_A    = 8'd65;
  localparam logic [7:0] CHAR_C    = 8'd67;
  localparam logic [7:0] CHAR_K    = 8'd75;

  // Input kinds carried on tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Kind of result burst one input item produces.
  typedef enum logic [1:0] {
    BK_ECHO = 2'd0,  // one word: the received byte
    BK_CRLF = 2'd1,  // two words: CR, LF
    BK_TICK = 2'd2,  // one word with no byte to send
    BK_ACK  = 2'd3   // five words: A, C, K, CR, LF
  } burst_kind_t;

  typedef struct packed {
    burst_kind_t kind;
    logic [7:0]  rx_byte;
    logic        level;
  } burst_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pulse_offset;
    logic [FT_W-1:0]     frame_ticks;
    logic [FCOUNT_W-1:0] frame_count;
  } cfg_t;

  // Number of result words in a burst, minus one.
  function automatic logic [2:0] burst_last_beat(burst_kind_t kind);
    logic [2:0] n;
    unique case (kind)
      BK_ECHO: n = 3'd0;
      BK_CRLF: n = 3'd1;
      BK_TICK: n = 3'd0;
      BK_ACK:  n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### design/acsp_cfg_regs.sv
module acsp_cfg_regs
  import acsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_offset <= PULSE_OFFSET_RST;
      cfg_r.frame_ticks  <= FRAME_TICKS_RST;
      cfg_r.frame_count  <= FRAME_COUNT_RST;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PULSE_OFFSET: cfg_r.pulse_offset <= cfg_wdata[OFFSET_W-1:0];
        REG_FRAME_TICKS:  cfg_r.frame_ticks  <= cfg_wdata[FT_W-1:0];
        REG_FRAME_COUNT:  cfg_r.frame_count  <= cfg_wdata[FCOUNT_W-1:0];
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/acsp_cmd_core.sv
module acsp_cmd_core
  import acsp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output burst_t     burst
);

  localparam int PW_W  = VALUE_BITS + 1;
  localparam int LEN_W = (PW_W > FT_W) ? PW_W : FT_W;
  localparam int ACC_W = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  logic [VALUE_BITS-1:0] accum_r, accum_nxt;
  logic                  active_r, active_nxt;
  logic [PW_W-1:0]       pw_r, pw_nxt;
  logic [LEN_W-1:0]      tick_r, tick_nxt;
  logic [FCOUNT_W-1:0]   frames_r, frames_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [VALUE_BITS-1:0] pend_value_r, pend_value_nxt;

  logic [ACC_W-1:0]    acc_wide;
  logic [LEN_W-1:0]    pw_ext, ft_ext, flen;
  logic [LEN_W:0]      tick_inc;
  logic [FCOUNT_W:0]   frames_inc;
  logic [FCOUNT_W-1:0] fcnt;
  logic                is_digit;

  // acc*10 + digit, built from two shifts.
  assign acc_wide = ACC_W'({accum_r, 3'b000}) + {3'b000, accum_r, 1'b0}
                  + ACC_W'(rx_byte[3:0]);
  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

  // Frame length is never shorter than the pulse and never zero.
  assign pw_ext = LEN_W'(pw_r);
  assign ft_ext = LEN_W'(cfg.frame_ticks);
  always_comb begin
    flen = (ft_ext > pw_ext) ? ft_ext : pw_ext;
    if (flen == '0) begin
      flen = LEN_W'(1);
    end
  end
  assign fcnt       = (cfg.frame_count == '0) ? FCOUNT_W'(1) : cfg.frame_count;
  assign tick_inc   = {1'b0, tick_r} + (LEN_W+1)'(1);
  assign frames_inc = {1'b0, frames_r} + (FCOUNT_W+1)'(1);

  always_comb begin
    accum_nxt      = accum_r;
    active_nxt     = active_r;
    pw_nxt         = pw_r;
    tick_nxt       = tick_r;
    frames_nxt     = frames_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    burst.kind     = BK_TICK;
    burst.rx_byte  = rx_byte;

    if (operation == OP_BYTE) begin
      if (rx_byte != CHAR_CR) begin
        burst.kind = BK_ECHO;
        if (is_digit) begin
          accum_nxt = (acc_wide > ACC_W'(VALUE_MAX)) ? VALUE_MAX : acc_wide[VALUE_BITS-1:0];
        end
      end else begin
        burst.kind = BK_CRLF;
        accum_nxt  = '0;
        if (!active_r) begin
          active_nxt = 1'b1;
          pw_nxt     = PW_W'(cfg.pulse_offset) + PW_W'(accum_r);
          tick_nxt   = '0;
          frames_nxt = '0;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_value_nxt = accum_r;
        end
      end
    end else if (active_r) begin
      tick_nxt = tick_inc[LEN_W-1:0];
      if (tick_inc >= {1'b0, flen}) begin
        tick_nxt   = '0;
        frames_nxt = frames_inc[FCOUNT_W-1:0];
        if (frames_inc >= {1'b0, fcnt}) begin
          // Train complete: acknowledge and launch the waiting command.
          burst.kind = BK_ACK;
          active_nxt = 1'b0;
          frames_nxt = '0;
          if (pend_valid_r) begin
            pend_valid_nxt = 1'b0;
            active_nxt     = 1'b1;
            pw_nxt         = PW_W'(cfg.pulse_offset) + PW_W'(pend_value_r);
            tick_nxt       = '0;
          end
        end
      end
    end

    burst.level = active_nxt && (tick_nxt < LEN_W'(pw_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      active_r     <= 1'b0;
      pw_r         <= '0;
      tick_r       <= '0;
      frames_r     <= '0;
      pend_valid_r <= 1'b0;
      pend_value_r <= '0;
    end else if (accept) begin
      accum_r      <= accum_nxt;
      active_r     <= active_nxt;
      pw_r         <= pw_nxt;
      tick_r       <= tick_nxt;
      frames_r     <= frames_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_value_r <= pend_value_nxt;
    end
  end

endmodule

### design/acsp_burst_out.sv
module acsp_burst_out
  import acsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  burst_t      burst,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  burst_kind_t kind_r;
  logic [7:0]  byte_r;
  logic        level_r;
  logic [2:0]  beat_r;
  logic        valid_r;

  logic       last_beat;
  logic       tx_valid;
  logic [7:0] tx_byte;

  assign last_beat = (beat_r == burst_last_beat(kind_r));
  assign can_load  = !valid_r || (out_tready && last_beat);

  always_comb begin
    tx_valid = 1'b1;
    tx_byte  = byte_r;
    unique case (kind_r)
      BK_ECHO: tx_byte = byte_r;
      BK_CRLF: tx_byte = (beat_r == 3'd0) ? CHAR_CR : CHAR_LF;
      BK_TICK: begin
        tx_valid = 1'b0;
        tx_byte  = 8'd0;
      end
      BK_ACK: begin
        unique case (beat_r)
          3'd0:    tx_byte = CHAR_A;
          3'd1:    tx_byte = CHAR_C;
          3'd2:    tx_byte = CHAR_K;
          3'd3:    tx_byte = CHAR_CR;
          default: tx_byte = CHAR_LF;
        endcase
      end
      default: tx_byte = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
    end else if (valid_r && out_tready) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= burst.kind;
      byte_r  <= burst.rx_byte;
      level_r <= burst.level;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_beat;
  assign out_tuser  = tx_valid;
  assign out_tdata  = {7'b0000000, level_r, tx_byte};

endmodule

### design/ascii_command_servo_pulse_train.sv
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | in_tdata: rx_byte; in_tuser: operation
// out_    | out | out_tvalid/out_tready | out_tdata: tx_byte, servo_level;
//         |     |                       | out_tuser: tx_valid; out_tlast: last
// cfg_    | in  | cfg_wen               | cfg_index, cfg_wdata
//
// Each accepted word updates the command state in the cycle it is taken and
// loads a result burst into the output register. A burst is 1 word (echo or
// tick), 2 words (CR LF) or 5 words (A C K CR LF), sent one word per cycle
// while out_tready is high. The output register's beat counter sets the rate:
// a new input word is taken in the same cycle the last word of the previous
// burst leaves, so items that yield one word each flow at one per cycle.
// Reset is synchronous and active low; state registers return to defaults
// (burst payload registers are not reset) and there is no clearing pass. A
// stall on the output holds the burst and back-pressures the input.
module ascii_command_servo_pulse_train
  import acsp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tuser,   // [0] operation: 0 byte, 1 tick
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [7:0] tx_byte, [8] servo_level,
                                           // [15:9] zero
  output logic                 out_tuser,  // [0] tx_valid
  output logic                 out_tlast,  // last word caused by one input word
  // Configuration write port.
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t   cfg;
  burst_t burst;
  logic   can_load;
  logic   in_accept;

  assign in_tready = can_load;
  assign in_accept = in_tvalid && can_load;

  // Pulse offset, frame length and frame count.
  acsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Digit accumulator, train counters and the pending command slot. The
  // servo level of the burst reflects the state after the word is applied.
  acsp_cmd_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .operation (in_tuser),
    .rx_byte   (in_tdata),
    .cfg       (cfg),
    .burst     (burst)
  );

  // Output register that plays out the burst one word per ready cycle.
  acsp_burst_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .burst      (burst),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // During a burst, a new word is only taken as its last word leaves.
  a_accept_at_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tvalid) |-> (out_tready && out_tlast))
    else $error("input taken while a burst was still in progress");

  // The final word leaving with no new input empties the output register.
  a_burst_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !(in_tvalid && in_tready))
      |=> !out_tvalid)
    else $error("output still valid after its burst ended");

  // Every word of one burst carries the same servo level.
  a_level_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast)
      |=> (out_tvalid && out_tdata[8] == $past(out_tdata[8])))
    else $error("servo level changed within a burst");

  // A word with no byte to send is always the last word of its burst.
  a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("empty word is not the last of its burst");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the servo pulse-train command block.
module testbench;
  import acsp_pkg::*;

  // The digit accumulator saturates here.
  localparam int ACC_MAX = (1 << VALUE_BITS_DEF) - 1;
  // The index port has one code with no register behind it; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  // Cycles with no word moving on either stream before the run is declared hung.
  // The longest legal quiet stretch is the receiver's long hold plus one stall.
  localparam int IDLE_LIMIT = 2000;
  // Length of the receiver's long hold, used to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles watched after the last expected word, to catch stray output.
  localparam int TAIL_CYCLES = 20;
  localparam int ITEM_TARGET = 250;
  localparam int RANDOM_PHASES = 5;
  // Only the first few mismatches are printed, so a broken build stays readable.
  localparam int REPORT_MAX = 30;

  // One result word as it appears on {out_tlast, out_tdata, out_tuser}, lowest bit last.
  typedef struct packed {
    logic       last;
    logic [6:0] pad;
    logic       level;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } servo_word_t;

  // One row of the directed script: either a register write or an input word.
  // A typed row carries its single result word, written out by hand.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic                 op;
    logic [7:0]           rx;
    bit                   typed;
    servo_word_t          want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'd0;   // [7:0] rx_byte
  logic                 in_tuser = 1'b0;   // [0] operation: 0 byte, 1 tick
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // [7:0] tx_byte, [8] servo_level,
                                           // [15:9] zero
  logic                 out_tuser;         // [0] tx_valid
  logic                 out_tlast;         // last word caused by one input word
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  ascii_command_servo_pulse_train u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copies, kept in step with every write the bench makes.
  logic [OFFSET_W-1:0] cur_offset = PULSE_OFFSET_RST;
  logic [FT_W-1:0]     cur_frame_ticks = FRAME_TICKS_RST;
  logic [FCOUNT_W-1:0] cur_frame_count = FRAME_COUNT_RST;

  // Command and train state, as the block should hold it after each input word.
  logic [VALUE_BITS_DEF-1:0] digits_acc = '0;
  logic                      train_on = 1'b0;
  logic [12:0]               train_pulse = '0;
  logic [12:0]               train_pos = '0;
  logic [7:0]                train_frames = '0;
  logic                      queued_on = 1'b0;
  logic [VALUE_BITS_DEF-1:0] queued_value = '0;

  // Words the block still owes, oldest first, and the burst of the latest input word.
  servo_word_t due_words[$];
  servo_word_t burst_words[$];

  // Sender and receiver pacing. pace_free turns off all random gaps on both sides
  // for a whole command or tick run, so back-to-back traffic is covered too.
  int          input_gap = 0;
  bit          pace_free = 1'b0;
  bit          hold_request = 1'b0;
  bit          typed_on = 1'b0;
  servo_word_t typed_word;
  int          words_sent = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic servo_word_t make_word(logic valid, logic [7:0] b, logic lvl,
                                            logic fin);
    servo_word_t w;
    w = '0;
    w.tx_valid = valid;
    w.tx_byte = valid ? b : 8'd0;
    w.level = lvl;
    w.last = fin;
    return w;
  endfunction

  // The pulse width is latched from the offset in force when the train starts.
  task automatic launch_train(input logic [VALUE_BITS_DEF-1:0] value);
    train_on = 1'b1;
    train_pulse = {5'd0, cur_offset} + {1'b0, value};
    train_pos = '0;
    train_frames = '0;
  endtask

  // Applies one input word to the command and train state and leaves the words
  // it should cause in burst_words.
  task automatic servo_cmd_predict(input logic op, input logic [7:0] rx);
    int unsigned grown;
    logic [12:0] frame_len;
    logic [7:0]  frames_needed;
    logic        ended;
    logic        lvl;
    logic [8:0]  sends[5];
    int          n;
    burst_words.delete();
    ended = 1'b0;
    n = 0;
    if (op == OP_BYTE) begin
      if (rx != CHAR_CR) begin
        sends[n++] = {1'b1, rx};
        if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
          grown = digits_acc * 10 + (rx - CHAR_ZERO);
          digits_acc = (grown > ACC_MAX) ? VALUE_BITS_DEF'(ACC_MAX)
                                         : grown[VALUE_BITS_DEF-1:0];
        end
      end else begin
        sends[n++] = {1'b1, CHAR_CR};
        sends[n++] = {1'b1, CHAR_LF};
        if (!train_on) begin
          launch_train(digits_acc);
        end else begin
          // A newer command overwrites whatever was already waiting.
          queued_on = 1'b1;
          queued_value = digits_acc;
        end
        digits_acc = '0;
      end
    end else begin
      if (train_on) begin
        // Frame settings are read live; a frame never ends before its pulse does,
        // and a zero frame count behaves like one.
        frame_len = ({1'b0, cur_frame_ticks} > train_pulse) ? {1'b0, cur_frame_ticks}
                                                            : train_pulse;
        if (frame_len == 0) frame_len = 13'd1;
        frames_needed = (cur_frame_count == 0) ? 8'd1 : cur_frame_count;
        train_pos = train_pos + 13'd1;
        if (train_pos >= frame_len) begin
          train_pos = '0;
          train_frames = train_frames + 8'd1;
          if (train_frames >= frames_needed) begin
            train_on = 1'b0;
            train_frames = '0;
            ended = 1'b1;
          end
        end
      end
      if (ended) begin
        sends[n++] = {1'b1, CHAR_A};
        sends[n++] = {1'b1, CHAR_C};
        sends[n++] = {1'b1, CHAR_K};
        sends[n++] = {1'b1, CHAR_CR};
        sends[n++] = {1'b1, CHAR_LF};
        if (queued_on) begin
          queued_on = 1'b0;
          launch_train(queued_value);
        end
      end else begin
        sends[n++] = 9'd0;
      end
    end
    lvl = train_on && (train_pos < train_pulse);
    for (int k = 0; k < n; k++)
      burst_words.push_back(make_word(sends[k][8], sends[k][7:0], lvl, k == n - 1));
  endtask

  // Offers one input word and, once it is taken, records the words it should cause.
  // Valid stays high into the next word when no gap is drawn, so it is never
  // dropped and raised in the same step.
  task automatic send_word(input logic op, input logic [7:0] rx);
    repeat (input_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    servo_cmd_predict(op, rx);
    if (typed_on) begin
      due_words.push_back(typed_word);
    end else begin
      foreach (burst_words[i]) due_words.push_back(burst_words[i]);
    end
    words_sent++;
    input_gap = pace_free ? 0 : $urandom_range(0, 14);
    if (input_gap > 0) in_tvalid <= 1'b0;
  endtask

  // Parks the input stream and waits until every owed word has been taken.
  // Each input word causes at least one result, so an empty list means the
  // block is idle and a register write is safe.
  task automatic wait_results_done();
    if (input_gap == 0) begin
      in_tvalid <= 1'b0;
      input_gap = 1;
    end
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high so back-to-back writes need no toggle;
  // the caller drops it before the next input word.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_PULSE_OFFSET: cur_offset = value[OFFSET_W-1:0];
      REG_FRAME_TICKS:  cur_frame_ticks = value[FT_W-1:0];
      REG_FRAME_COUNT:  cur_frame_count = value[FCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  // A decimal command with random content. Now and then a stray byte leads it
  // or the carriage return is left off, so the next command inherits the digits.
  task automatic send_command();
    logic [7:0]  digs[$];
    int unsigned value;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) value = $urandom_range(0, 20);
    else if (pick < 95) value = $urandom_range(21, 300);
    else value = $urandom_range(ACC_MAX + 1, 99999);
    do begin
      digs.push_front(CHAR_ZERO + 8'(value % 10));
      value = value / 10;
    end while (value != 0);
    if ($urandom_range(0, 6) == 0) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
    foreach (digs[i]) send_word(OP_BYTE, digs[i]);
    if ($urandom_range(0, 9) != 0) send_word(OP_BYTE, CHAR_CR);
  endtask

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    script_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = value;
    r.op = OP_BYTE;
    r.rx = 8'd0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic script_row_t word_row(logic op, logic [7:0] rx, bit typed,
                                           servo_word_t want);
    script_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.value = '0;
    r.op = op;
    r.rx = rx;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Result side: random stalls per word, and once a long hold on request while
  // the sender keeps offering, so the block fills up and stops taking input.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = pace_free ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Every word taken from the block is checked against the oldest owed word.
  always @(posedge clk) begin : result_check
    servo_word_t got;
    servo_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata, out_tuser};
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t ns: unexpected word, expected none, got tx_valid=%0b tx_byte=%02h %s%0b %s%0b",
                   $time, got.tx_valid, got.tx_byte, "level=", got.level, "last=", got.last);
      end else begin
        want = due_words.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
            got.level !== want.level || got.last !== want.last || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t ns: expected valid=%0b byte=%02h level=%0b last=%0b pad=%02h, %s",
                     $time, want.tx_valid, want.tx_byte, want.level, want.last, want.pad,
                     $sformatf("got valid=%0b byte=%02h level=%0b last=%0b pad=%02h",
                               got.tx_valid, got.tx_byte, got.level, got.last, got.pad));
        end
      end
    end
  end

  // Hang detection: a long run of cycles in which neither stream moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ascii_command_servo_pulse_train: mismatch");
        $finish;
      end
    end
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    bit          writing;
    bit          pressure_done;
    int          phase;
    int          phase_stop;
    int          pick;

    // Directed script. Rows with a result written out are the ones that can be
    // read off directly: ticks and echoes while no train runs.
    // A tick with no train gives one empty word at level low.
    script.push_back(word_row(OP_TICK, 8'hA5, 1'b1, make_word(1'b0, 8'h00, 1'b0, 1'b1)));
    // Byte extremes are echoed unchanged.
    script.push_back(word_row(OP_BYTE, 8'h00, 1'b1, make_word(1'b1, 8'h00, 1'b0, 1'b1)));
    script.push_back(word_row(OP_BYTE, 8'hFF, 1'b1, make_word(1'b1, 8'hFF, 1'b0, 1'b1)));
    // A write to the unused index must change nothing. Frame ticks of zero make
    // the frame as long as the pulse, and a zero frame count acts as one.
    script.push_back(cfg_row(REG_UNMAPPED, 12'hFFF));
    script.push_back(cfg_row(REG_PULSE_OFFSET, 12'd2));
    script.push_back(cfg_row(REG_FRAME_TICKS, 12'd0));
    script.push_back(cfg_row(REG_FRAME_COUNT, 12'd0));
    // An empty line commands value zero: a two-tick pulse, one frame, then ACK.
    script.push_back(word_row(OP_BYTE, CHAR_CR, 1'b0, '0));
    script.push_back(word_row(OP_TICK, 8'h5A, 1'b0, '0));
    script.push_back(word_row(OP_TICK, 8'h3C, 1'b0, '0));
    // Start a four-tick train, then queue a saturated value behind it and
    // replace that with an empty line while it still waits.
    script.push_back(word_row(OP_BYTE, CHAR_ZERO + 8'd2, 1'b1,
                              make_word(1'b1, CHAR_ZERO + 8'd2, 1'b0, 1'b1)));
    script.push_back(word_row(OP_BYTE, CHAR_CR, 1'b0, '0));
    repeat (4) script.push_back(word_row(OP_BYTE, CHAR_NINE, 1'b0, '0));
    script.push_back(word_row(OP_BYTE, CHAR_CR, 1'b0, '0));
    script.push_back(word_row(OP_BYTE, CHAR_CR, 1'b0, '0));
    // The fourth tick ends the train and starts the queued one.
    repeat (4) script.push_back(word_row(OP_TICK, 8'hC3, 1'b0, '0));
    // Registers changed under a running train: the pulse keeps its latched width,
    // while the new frame length and count apply at once.
    script.push_back(cfg_row(REG_PULSE_OFFSET, 12'd200));
    script.push_back(cfg_row(REG_FRAME_TICKS, 12'd1));
    script.push_back(cfg_row(REG_FRAME_COUNT, 12'd2));
    repeat (4) script.push_back(word_row(OP_TICK, 8'h0F, 1'b0, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        if (!writing) wait_results_done();
        writing = 1'b1;
        write_reg(row.idx, row.value);
      end else begin
        cfg_wen <= 1'b0;
        writing = 1'b0;
        typed_on = row.typed;
        typed_word = row.want;
        send_word(row.op, row.rx);
      end
    end
    typed_on = 1'b0;

    // Random phases. The first runs at the low register extremes and the last at
    // the high ones; short frames in between let trains finish often. Traffic is
    // mostly commands and runs of ticks, with a little loose noise.
    pressure_done = 1'b0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_results_done();
      if (phase == 0) begin
        write_reg(REG_PULSE_OFFSET, 12'd0);
        write_reg(REG_FRAME_TICKS, 12'd1);
        write_reg(REG_FRAME_COUNT, 12'd1);
      end else if (phase == RANDOM_PHASES - 1) begin
        write_reg(REG_PULSE_OFFSET, 12'd255);
        write_reg(REG_FRAME_TICKS, 12'd4095);
        write_reg(REG_FRAME_COUNT, 12'd255);
      end else begin
        write_reg(REG_PULSE_OFFSET, CFG_W'($urandom_range(0, 12)));
        write_reg(REG_FRAME_TICKS, CFG_W'($urandom_range(1, 30)));
        write_reg(REG_FRAME_COUNT, CFG_W'($urandom_range(1, 4)));
      end
      cfg_wen <= 1'b0;
      phase_stop = words_sent + (ITEM_TARGET - words_sent) / (RANDOM_PHASES - phase);
      while (words_sent < phase_stop) begin
        pace_free = ($urandom_range(0, 3) == 0);
        if (phase == 2 && !pressure_done) begin
          pace_free = 1'b1;
          hold_request = 1'b1;
          pressure_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_command();
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 25)) send_word(OP_TICK, 8'($urandom_range(0, 255)));
        end else begin
          send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ascii_command_servo_pulse_train: match");
    end else begin
      $display("ascii_command_servo_pulse_train: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/acsp_pkg.sv
design/acsp_cfg_regs.sv
design/acsp_cmd_core.sv
design/acsp_burst_out.sv
design/ascii_command_servo_pulse_train.sv
tb/testbench.sv
